### hdl/mmft_pkg.sv
// Package with shared types and constants for the flight timer bank.
package mmft_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_NV0,
    S_NV1,
    S_NV2,
    S_EMIT,
    S_RESET
  } seq_t;

  localparam int CFG_TIMERS = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 15;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam int IDX_BIT  = 0;
  localparam int TICK_LSB = 1;
  localparam int THR_LSB  = 9;
  localparam int EN_BIT   = 17;
  localparam int SW_LSB   = 18;

  localparam int SEC_W   = 16;
  localparam int ACC_W   = 9;
  localparam int SUM_W   = 32;
  localparam int CNT_W   = 16;
  localparam int START_W = 15;
  localparam int MODE_W  = 3;
  localparam int KIND_W  = 2;
  localparam int TICK_W  = 8;
  localparam int THR_W   = 8;
  localparam int SW_W    = 2;
  localparam int FULL_SHIFT = 7;

  localparam logic [ACC_W-1:0] CENTI_PER_SEC = 9'd100;
  localparam logic [ACC_W-1:0] ACC_MAX       = 9'd511;
  localparam logic [THR_W-1:0] THR_TRIGGER   = 8'd13;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_RESET = 1'b1;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_START  = 2'd1;
  localparam logic [1:0] REG_KIND   = 2'd2;
  localparam logic [1:0] REG_MINUTE = 2'd3;

  localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ABS    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_THR    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REL    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TRIG   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SWITCH = 3'd5;

  localparam logic [1:0] RS_OFF  = 2'd0;
  localparam logic [1:0] RS_RUN  = 2'd1;
  localparam logic [1:0] RS_NEG  = 2'd2;
  localparam logic [1:0] RS_STOP = 2'd3;

  localparam logic [2:0] AN_NONE    = 3'd0;
  localparam logic [2:0] AN_ZERO    = 3'd1;
  localparam logic [2:0] AN_THIRTY  = 3'd2;
  localparam logic [2:0] AN_TWENTY  = 3'd3;
  localparam logic [2:0] AN_UNDER10 = 3'd4;
  localparam logic [2:0] AN_MINUTE  = 3'd5;

endpackage

### hdl/multi_mode_flight_timer.sv
// Top level of the flight timer bank: config registers, sequencer and shared adder.
//
// Channels: the s_ side takes requests. s_tuser is the op (0 tick, 1 reset one
// timer); s_tdata holds the timer index, tick count, throttle level, throttle
// enable and switch bits. The m_ side returns one result per timer for a tick
// request, in timer order, or one result for a reset request; m_tlast marks
// the final result of a request. A reset request naming a missing timer
// returns nothing. Config registers, written through cfg_we/cfg_addr/
// cfg_wdata, must be written only while the bank is idle (not enforced).
// Flow: one request is worked on at a time and s_tready is high only when
// the sequencer is idle. A tick request is accepted and then works on each
// timer in turn: a load step, then, when a second elapses, three passes
// through the shared 16-bit adder, then a result step. A reset request
// passes through a reset step and then a result step. The result register
// is free again once taken; a stalled receiver holds the sequencer at its
// result step, and a new request can be accepted while the last result of
// the previous one still waits.
// Reset: timers off with zero value and counters, config zeroed, sequencer idle, m_tvalid low.
module multi_mode_flight_timer #(
  parameter int NUM_TIMERS       = 2,
  parameter int VALUE_HIGH_LIMIT = 32757,
  parameter int VALUE_LOW_LIMIT  = -32758,
  parameter int ALERT_WINDOW     = 60
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mmft_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [mmft_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // timer_index[0], tick_count[8:1], throttle_level[16:9], throttle_enable[17],
  // switch_bits[19:18], zeros[23:20]
  input  logic [mmft_pkg::IN_DATA_W-1:0]   s_tdata,
  // op[0]
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // which_timer[0], timer_value[16:1], run_state[18:17], announce[21:19],
  // beep_kind[23:22]
  output logic [mmft_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                             m_tlast
);
  import mmft_pkg::*;

  localparam int TW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [TW-1:0] LAST_T = TW'(NUM_TIMERS - 1);
  localparam logic signed [SEC_W-1:0] HI_LIM = SEC_W'(VALUE_HIGH_LIMIT);
  localparam logic signed [SEC_W-1:0] LO_LIM = SEC_W'(VALUE_LOW_LIMIT);
  localparam logic [17:0] ALERT = 18'(ALERT_WINDOW);

  logic [MODE_W-1:0]  cfg_mode   [CFG_TIMERS];
  logic [START_W-1:0] cfg_start  [CFG_TIMERS];
  logic [KIND_W-1:0]  cfg_kind   [CFG_TIMERS];
  logic               cfg_minute [CFG_TIMERS];

  logic [1:0]              t_state [NUM_TIMERS];
  logic signed [SEC_W-1:0] t_sec   [NUM_TIMERS];
  logic [ACC_W-1:0]        t_acc   [NUM_TIMERS];
  logic [SUM_W-1:0]        t_sum   [NUM_TIMERS];
  logic [CNT_W-1:0]        t_cnt   [NUM_TIMERS];

  seq_t          seq, seq_next;
  logic [TW-1:0] cur, cur_next;

  logic              in_reset_op;
  logic [TICK_W-1:0] in_tick;
  logic [THR_W-1:0]  in_thr;
  logic [SW_W-1:0]   in_sw;

  logic [1:0]              w_state;
  logic signed [SEC_W-1:0] w_sec;
  logic signed [SEC_W-1:0] w_nv;
  logic [ACC_W-1:0]        w_acc;
  logic [SUM_W-1:0]        w_sum;
  logic [CNT_W-1:0]        w_cnt;
  logic                    w_upd;
  logic                    w_inc;
  logic [2:0]              w_ann;

  logic              o_which;
  logic [SEC_W-1:0]  o_sec;
  logic [1:0]        o_state;
  logic [2:0]        o_ann;
  logic [KIND_W-1:0] o_kind;
  logic              o_last;

  logic               cfg_here;
  logic [MODE_W-1:0]  cur_mode;
  logic [START_W-1:0] cur_start;
  logic [KIND_W-1:0]  cur_kind;
  logic               cur_minute;
  logic               start_nz;
  logic               mode_valid;

  logic               start_run;
  logic [1:0]         ld_state;
  logic [SUM_W-1:0]   ld_sum;
  logic [CNT_W-1:0]   ld_cnt;
  logic [SUM_W:0]     sum_ext;
  logic [ACC_W:0]     acc_ext;
  logic [ACC_W-1:0]   ld_acc;
  logic               sec_due;

  logic [SUM_W-1:0]   rel_thresh;
  logic               rel_hit;
  logic               trig_hit;
  logic               inc_now;

  logic [SEC_W-1:0]   alu_a, alu_b, alu_y;
  logic               alu_sub;

  logic [17:0]        nv_x, start_x;
  logic               ge_start, ge_alert;

  logic [5:0]         dsum;
  logic [6:0]         dadj;
  logic               div60;
  logic               chg;
  logic [2:0]         ann;
  logic               out_free;
  logic               emit_fire;
  logic               last_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CFG_TIMERS; i++) begin
        cfg_mode[i]   <= MODE_OFF;
        cfg_start[i]  <= '0;
        cfg_kind[i]   <= '0;
        cfg_minute[i] <= 1'b0;
      end
    end else if (cfg_we) begin
      case (cfg_addr[2:1])
        REG_MODE:   cfg_mode[cfg_addr[0]]   <= cfg_wdata[MODE_W-1:0];
        REG_START:  cfg_start[cfg_addr[0]]  <= cfg_wdata[START_W-1:0];
        REG_KIND:   cfg_kind[cfg_addr[0]]   <= cfg_wdata[KIND_W-1:0];
        REG_MINUTE: cfg_minute[cfg_addr[0]] <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg_here   = (int'(cur) < CFG_TIMERS);
  assign cur_mode   = cfg_here ? cfg_mode[cur[0]] : MODE_OFF;
  assign cur_start  = cfg_here ? cfg_start[cur[0]] : '0;
  assign cur_kind   = cfg_here ? cfg_kind[cur[0]] : '0;
  assign cur_minute = cfg_here ? cfg_minute[cur[0]] : 1'b0;
  assign start_nz   = (cur_start != '0);

  always_comb begin
    case (cur_mode) inside
      [MODE_ABS:MODE_SWITCH]: mode_valid = 1'b1;
      default:                mode_valid = 1'b0;
    endcase
  end

  // Load step: start the timer, update averages and the centisecond accumulator
  always_comb begin
    start_run = mode_valid && (t_state[cur] == RS_OFF) && (cur_mode != MODE_TRIG);
    ld_state  = start_run ? RS_RUN : t_state[cur];
    ld_sum    = start_run ? '0 : t_sum[cur];
    ld_cnt    = start_run ? '0 : t_cnt[cur];
    sum_ext   = {1'b0, ld_sum} + {{(SUM_W + 1 - THR_W){1'b0}}, in_thr};
    if (cur_mode == MODE_REL) begin
      ld_sum = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      ld_cnt = (ld_cnt == '1) ? ld_cnt : ld_cnt + 1'b1;
    end
    acc_ext = {1'b0, t_acc[cur]} + {{(ACC_W + 1 - TICK_W){1'b0}}, in_tick};
    ld_acc  = acc_ext[ACC_W] ? ACC_MAX : acc_ext[ACC_W-1:0];
    sec_due = (ld_acc >= CENTI_PER_SEC) && (t_sec[cur] != HI_LIM) && (t_sec[cur] != LO_LIM);
  end

  // Second step: decide whether the timer advances
  always_comb begin
    rel_thresh = {{(SUM_W - CNT_W - FULL_SHIFT){1'b0}}, w_cnt, {FULL_SHIFT{1'b0}}};
    rel_hit    = (cur_mode == MODE_REL) && (w_cnt != '0) && (w_sum >= rel_thresh);
    trig_hit   = (cur_mode == MODE_TRIG) && (in_thr > THR_TRIGGER) && (w_state == RS_OFF);
    case (cur_mode)
      MODE_ABS:    inc_now = 1'b1;
      MODE_THR:    inc_now = (in_thr != '0);
      MODE_REL:    inc_now = rel_hit;
      MODE_TRIG:   inc_now = trig_hit || (w_state != RS_OFF);
      MODE_SWITCH: inc_now = (int'(cur) < SW_W) && in_sw[cur[0]];
      default:     inc_now = 1'b0;
    endcase
  end

  // Shared 16-bit adder
  always_comb begin
    alu_a   = {1'b0, cur_start};
    alu_b   = w_nv;
    alu_sub = 1'b1;
    case (seq)
      S_NV0: begin
        alu_b = w_sec;
      end
      S_NV1: begin
        alu_a   = w_nv;
        alu_b   = {{(SEC_W - 1){1'b0}}, w_inc};
        alu_sub = 1'b0;
      end
      default: ;
    endcase
    alu_y = alu_sub ? alu_a - alu_b : alu_a + alu_b;
  end

  assign nv_x     = {{2{w_nv[SEC_W-1]}}, w_nv};
  assign start_x  = {3'b000, cur_start};
  assign ge_start = ($signed(nv_x) >= $signed(start_x));
  assign ge_alert = ($signed(nv_x) >= $signed(start_x + ALERT));

  // Whole minute test: divisible by 4 and, by hex digit sum, by 15
  always_comb begin
    dsum = 6'(w_nv[3:0]) + 6'(w_nv[7:4]) + 6'(w_nv[11:8]) + 6'(w_nv[15:12]);
    dadj = 7'(dsum) + 7'd15 - 7'(w_nv[SEC_W-1]);
    case (dadj) inside
      7'd15, 7'd30, 7'd45, 7'd60, 7'd75: div60 = (w_nv[1:0] == 2'b00);
      default:                          div60 = 1'b0;
    endcase
  end

  always_comb begin
    chg = w_upd && (w_nv != w_sec);
    ann = w_ann;
    if (chg && (w_state == RS_RUN)) begin
      if ((cur_kind != '0) && start_nz) begin
        if (w_nv == 16'sd30) begin
          ann = AN_THIRTY;
        end else if (w_nv == 16'sd20) begin
          ann = AN_TWENTY;
        end else if (w_nv <= 16'sd10) begin
          ann = AN_UNDER10;
        end
      end
      if ((ann == AN_NONE) && cur_minute && div60) begin
        ann = AN_MINUTE;
      end
    end
  end

  assign out_free  = !m_tvalid || m_tready;
  assign emit_fire = (seq == S_EMIT) && out_free;
  assign last_item = in_reset_op || (cur == LAST_T);
  assign s_tready  = (seq == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= S_IDLE;
      cur <= '0;
    end else begin
      seq <= seq_next;
      cur <= cur_next;
    end
  end

  always_comb begin
    seq_next = seq;
    cur_next = cur;
    case (seq)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == OP_RESET) begin
            if (int'(s_tdata[IDX_BIT]) < NUM_TIMERS) begin
              seq_next = S_RESET;
              cur_next = TW'(s_tdata[IDX_BIT]);
            end
          end else begin
            seq_next = S_LOAD;
            cur_next = '0;
          end
        end
      end
      S_LOAD:  seq_next = (mode_valid && sec_due) ? S_NV0 : S_EMIT;
      S_NV0:   seq_next = S_NV1;
      S_NV1:   seq_next = S_NV2;
      S_NV2:   seq_next = S_EMIT;
      S_RESET: seq_next = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          if (last_item) begin
            seq_next = S_IDLE;
          end else begin
            seq_next = S_LOAD;
            cur_next = cur + 1'b1;
          end
        end
      end
      default: seq_next = S_IDLE;
    endcase
  end

  // Request capture and working registers
  always_ff @(posedge clk) begin
    case (seq)
      S_IDLE: begin
        in_reset_op <= s_tuser;
        in_tick     <= s_tdata[TICK_LSB +: TICK_W];
        in_thr      <= s_tdata[EN_BIT] ? s_tdata[THR_LSB +: THR_W] : '0;
        in_sw       <= s_tdata[SW_LSB +: SW_W];
      end
      S_LOAD: begin
        w_sec <= t_sec[cur];
        w_nv  <= t_sec[cur];
        w_ann <= AN_NONE;
        w_inc <= 1'b0;
        if (mode_valid) begin
          w_state <= ld_state;
          w_sum   <= ld_sum;
          w_cnt   <= ld_cnt;
          w_acc   <= sec_due ? ld_acc - CENTI_PER_SEC : ld_acc;
          w_upd   <= sec_due;
        end else begin
          w_state <= t_state[cur];
          w_sum   <= t_sum[cur];
          w_cnt   <= t_cnt[cur];
          w_acc   <= t_acc[cur];
          w_upd   <= 1'b0;
        end
      end
      S_NV0: begin
        w_nv  <= start_nz ? $signed(alu_y) : w_sec;
        w_inc <= inc_now;
        if (rel_hit) begin
          w_sum <= w_sum - rel_thresh;
        end
        if (cur_mode == MODE_REL) begin
          w_cnt <= '0;
        end
        if (trig_hit) begin
          w_state <= RS_RUN;
          w_sum   <= '0;
          w_cnt   <= '0;
        end
      end
      S_NV1: begin
        w_nv <= $signed(alu_y);
      end
      S_NV2: begin
        if (w_state == RS_RUN) begin
          if (start_nz && ge_start) begin
            w_state <= RS_NEG;
            w_ann   <= AN_ZERO;
          end
        end else if (w_state == RS_NEG) begin
          if (ge_alert) begin
            w_state <= RS_STOP;
          end
        end
        if (start_nz) begin
          w_nv <= $signed(alu_y);
        end
      end
      S_RESET: begin
        w_state <= RS_OFF;
        w_sec   <= $signed({1'b0, cur_start});
        w_nv    <= $signed({1'b0, cur_start});
        w_acc   <= '0;
        w_sum   <= t_sum[cur];
        w_cnt   <= t_cnt[cur];
        w_upd   <= 1'b0;
        w_inc   <= 1'b0;
        w_ann   <= AN_NONE;
      end
      default: ;
    endcase
  end

  // Timer state write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        t_state[i] <= RS_OFF;
        t_sec[i]   <= '0;
        t_acc[i]   <= '0;
        t_sum[i]   <= '0;
        t_cnt[i]   <= '0;
      end
    end else if (emit_fire) begin
      t_state[cur] <= w_state;
      t_sec[cur]   <= w_upd ? w_nv : w_sec;
      t_acc[cur]   <= w_acc;
      t_sum[cur]   <= w_sum;
      t_cnt[cur]   <= w_cnt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      o_which <= cur[0];
      o_sec   <= w_upd ? w_nv : w_sec;
      o_state <= w_state;
      o_ann   <= ann;
      o_kind  <= (ann != AN_NONE) ? cur_kind : '0;
      o_last  <= last_item;
    end
  end

  assign m_tdata = {o_kind, o_ann, o_state, o_sec, o_which};
  assign m_tlast = o_last;

  a_tick_starts_at_first: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_TICK) |=> (seq == S_LOAD) && (cur == '0))
    else $error("tick request did not start at the first timer");

  a_cur_in_range: assert property (@(posedge clk) disable iff (rst)
    (seq != S_IDLE) |-> (int'(cur) < NUM_TIMERS))
    else $error("timer cursor out of range");

  a_off_is_silent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (o_state == RS_OFF) |-> (o_ann == AN_NONE))
    else $error("announcement from a timer that is off");

  a_zero_enters_alert: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (o_ann == AN_ZERO) |-> (o_state == RS_NEG))
    else $error("zero reached without entering the alert window");

  a_kind_only_with_announce: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (o_ann == AN_NONE) |-> (o_kind == '0))
    else $error("beep kind without announcement");

endmodule

### dv/multi_mode_flight_timer_tb.sv
// Self-checking testbench for the flight timer bank: predicts every timer result and compares.
module multi_mode_flight_timer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mmft_pkg::*;

  localparam int NUM_TIMERS    = 2;
  localparam int HIGH_LIMIT    = 32757;
  localparam int LOW_LIMIT     = -32758;
  localparam int ALERT_WINDOW  = 60;
  localparam int FULL_THROTTLE = 128;
  localparam int SECS_PER_MIN  = 60;
  localparam int MARK_THIRTY   = 30;
  localparam int MARK_TWENTY   = 20;
  localparam int MARK_TEN      = 10;
  localparam int SAMPLE_MAX    = 65535;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int ITEM_TARGET   = 1250;

  typedef struct packed {
    logic        which;
    logic [15:0] value;
    logic [1:0]  state;
    logic [2:0]  ann;
    logic [1:0]  beep;
    logic        last;
  } timer_report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  logic [MODE_W-1:0] mode_reg [NUM_TIMERS];
  int                start_reg [NUM_TIMERS];
  logic [KIND_W-1:0] kind_reg [NUM_TIMERS];
  logic              minute_reg [NUM_TIMERS];

  logic [1:0]  run_st [NUM_TIMERS];
  int          secs [NUM_TIMERS];
  int unsigned centi [NUM_TIMERS];
  bit [31:0]   thr_acc [NUM_TIMERS];
  int unsigned thr_samples [NUM_TIMERS];

  timer_report_t expected_reports [$];
  int            errors = 0;
  int            items_sent = 0;
  int            cycles = 0;
  bit            steady_flow = 1'b0;
  bit            hold_off = 1'b0;

  multi_mode_flight_timer #(
    .NUM_TIMERS      (NUM_TIMERS),
    .VALUE_HIGH_LIMIT(HIGH_LIMIT),
    .VALUE_LOW_LIMIT (LOW_LIMIT),
    .ALERT_WINDOW    (ALERT_WINDOW)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int to_s16(int x);
    logic signed [15:0] w;
    w = x[15:0];
    return w;
  endfunction

  function automatic logic [2:0] advance_timer(int i, int unsigned tick, int unsigned thr,
                                               logic [1:0] sw);
    logic [MODE_W-1:0] mode;
    int st, v, nv;
    bit inc;
    logic [2:0] ann;
    mode = mode_reg[i];
    st = start_reg[i];
    inc = 1'b0;
    ann = AN_NONE;
    if (mode < MODE_ABS || mode > MODE_SWITCH) return AN_NONE;
    if (run_st[i] == RS_OFF && mode != MODE_TRIG) begin
      run_st[i] = RS_RUN;
      thr_samples[i] = 0;
      thr_acc[i] = 0;
    end
    if (mode == MODE_REL) begin
      if (thr_samples[i] < SAMPLE_MAX) thr_samples[i]++;
      if (thr_acc[i] > 32'hFFFF_FFFF - thr) thr_acc[i] = 32'hFFFF_FFFF;
      else thr_acc[i] += thr;
    end
    centi[i] += tick;
    if (centi[i] > ACC_MAX) centi[i] = ACC_MAX;
    if (centi[i] < CENTI_PER_SEC) return AN_NONE;
    v = secs[i];
    if (v == HIGH_LIMIT || v == LOW_LIMIT) return AN_NONE;
    centi[i] -= CENTI_PER_SEC;
    nv = (st != 0) ? to_s16(st - v) : v;
    case (mode)
      MODE_ABS: inc = 1'b1;
      MODE_THR: inc = (thr != 0);
      MODE_REL: begin
        if (thr_samples[i] != 0 && thr_acc[i] / thr_samples[i] >= FULL_THROTTLE) begin
          inc = 1'b1;
          thr_acc[i] -= FULL_THROTTLE * thr_samples[i];
        end
        thr_samples[i] = 0;
      end
      MODE_TRIG: begin
        if (thr > THR_TRIGGER && run_st[i] == RS_OFF) begin
          run_st[i] = RS_RUN;
          thr_samples[i] = 0;
          thr_acc[i] = 0;
        end
        inc = (run_st[i] != RS_OFF);
      end
      default: inc = sw[i];
    endcase
    if (inc) nv = to_s16(nv + 1);
    if (run_st[i] == RS_RUN) begin
      if (st != 0 && nv >= st) begin
        ann = AN_ZERO;
        run_st[i] = RS_NEG;
      end
    end else if (run_st[i] == RS_NEG) begin
      if (nv >= st + ALERT_WINDOW) run_st[i] = RS_STOP;
    end
    if (st != 0) nv = to_s16(st - nv);
    if (nv != v) begin
      secs[i] = nv;
      if (run_st[i] == RS_RUN) begin
        if (kind_reg[i] != 0 && st != 0) begin
          if (nv == MARK_THIRTY) ann = AN_THIRTY;
          else if (nv == MARK_TWENTY) ann = AN_TWENTY;
          else if (nv <= MARK_TEN) ann = AN_UNDER10;
        end
        if (ann == AN_NONE && minute_reg[i] && nv % SECS_PER_MIN == 0) ann = AN_MINUTE;
      end
    end
    return ann;
  endfunction

  function automatic void predict_request(logic op, logic idx, logic [7:0] tick,
                                          logic [7:0] thr, logic en, logic [1:0] sw);
    timer_report_t r;
    int unsigned thr_eff;
    logic [2:0] ann;
    if (op == OP_RESET) begin
      run_st[idx] = RS_OFF;
      secs[idx] = start_reg[idx];
      centi[idx] = 0;
      r.which = idx;
      r.value = secs[idx][15:0];
      r.state = RS_OFF;
      r.ann = AN_NONE;
      r.beep = 2'd0;
      r.last = 1'b1;
      expected_reports.push_back(r);
    end else begin
      thr_eff = en ? thr : 0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        ann = advance_timer(i, tick, thr_eff, sw);
        r.which = i[0];
        r.value = secs[i][15:0];
        r.state = run_st[i];
        r.ann = ann;
        r.beep = (ann != AN_NONE) ? kind_reg[i] : 2'd0;
        r.last = (i == NUM_TIMERS - 1);
        expected_reports.push_back(r);
      end
    end
  endfunction

  task automatic send_request(logic op, logic idx, logic [7:0] tick, logic [7:0] thr,
                              logic en, logic [1:0] sw);
    int gap;
    gap = 0;
    if (!steady_flow && $urandom_range(99) < 35) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {4'b0, sw, en, thr, tick, idx};
    do @(posedge clk); while (!s_tready);
    predict_request(op, idx, tick, thr, en, sw);
    items_sent++;
  endtask

  task automatic idle_bank();
    s_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] field, logic t, int value);
    cfg_we <= 1'b1;
    cfg_addr <= {field, t};
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    case (field)
      REG_MODE:  mode_reg[t] = value[MODE_W-1:0];
      REG_START: start_reg[t] = int'(value[START_W-1:0]);
      REG_KIND:  kind_reg[t] = value[KIND_W-1:0];
      default:   minute_reg[t] = value[0];
    endcase
  endtask

  task automatic apply_setting(int m0, int m1, int s0, int s1, int k0, int k1, int b0, int b1);
    write_reg(REG_MODE, 1'b0, m0);
    write_reg(REG_MODE, 1'b1, m1);
    write_reg(REG_START, 1'b0, s0);
    write_reg(REG_START, 1'b1, s1);
    write_reg(REG_KIND, 1'b0, k0);
    write_reg(REG_KIND, 1'b1, k1);
    write_reg(REG_MINUTE, 1'b0, b0);
    write_reg(REG_MINUTE, 1'b1, b1);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_tick();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(100, 255);
    if (r < 75) return $urandom_range(0, 99);
    if (r < 85) return 8'd0;
    return 8'd255;
  endfunction

  function automatic logic [7:0] pick_throttle();
    int r;
    r = $urandom_range(99);
    if (r < 30) return FULL_THROTTLE;
    if (r < 50) return $urandom_range(12, 15);
    if (r < 65) return 8'd0;
    return $urandom_range(0, FULL_THROTTLE);
  endfunction

  function automatic int pick_mode();
    int r;
    r = $urandom_range(99);
    if (r < 8) return MODE_OFF;
    if (r < 14) return $urandom_range(6, 7);
    return $urandom_range(MODE_ABS, MODE_SWITCH);
  endfunction

  function automatic int pick_start();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 0;
    if (r < 75) return $urandom_range(1, 120);
    if (r < 88) return $urandom_range(32700, 32767);
    return $urandom_range(0, 32767);
  endfunction

  task automatic random_request();
    logic op;
    op = ($urandom_range(99) < 6) ? OP_RESET : OP_TICK;
    send_request(op, $urandom_range(1), pick_tick(), pick_throttle(),
                 $urandom_range(99) < 85, $urandom_range(3));
  endtask

  task automatic run_ticks(int n);
    logic [1:0] sw;
    repeat (n) begin
      sw = ($urandom_range(9) < 8) ? 2'b11 : 2'($urandom_range(3));
      send_request(OP_TICK, $urandom_range(1), $urandom_range(100, 255), pick_throttle(),
                   $urandom_range(99) < 85, sw);
    end
  endtask

  task automatic test_field_extremes();
    send_request(OP_TICK, 1'b0, 8'd0, 8'd0, 1'b0, 2'b00);
    send_request(OP_TICK, 1'b1, 8'd255, 8'd128, 1'b1, 2'b11);
    send_request(OP_RESET, 1'b0, 8'd0, 8'd0, 1'b0, 2'b00);
    send_request(OP_RESET, 1'b1, 8'd255, 8'd128, 1'b1, 2'b11);
    idle_bank();
    apply_setting(MODE_ABS, MODE_SWITCH, 0, 32767, 3, 0, 1, 1);
    send_request(OP_RESET, 1'b1, 8'd0, 8'd0, 1'b0, 2'b00);
    send_request(OP_TICK, 1'b0, 8'd255, 8'd0, 1'b0, 2'b00);
    send_request(OP_TICK, 1'b1, 8'd255, 8'd128, 1'b1, 2'b10);
    send_request(OP_TICK, 1'b0, 8'd100, 8'd64, 1'b1, 2'b01);
    send_request(OP_TICK, 1'b0, 8'd99, 8'd1, 1'b1, 2'b11);
    send_request(OP_TICK, 1'b0, 8'd1, 8'd0, 1'b1, 2'b11);
    send_request(OP_TICK, 1'b1, 8'd255, 8'd128, 1'b1, 2'b11);
    send_request(OP_RESET, 1'b0, 8'd0, 8'd0, 1'b0, 2'b00);
    idle_bank();
    apply_setting(6, 7, 100, 5, 1, 2, 0, 1);
    send_request(OP_TICK, 1'b0, 8'd255, 8'd128, 1'b1, 2'b11);
    send_request(OP_TICK, 1'b1, 8'd200, 8'd0, 1'b0, 2'b00);
    idle_bank();
    apply_setting(MODE_REL, MODE_TRIG, 0, 20, 2, 3, 1, 0);
    send_request(OP_TICK, 1'b0, 8'd150, 8'd13, 1'b1, 2'b00);
    send_request(OP_TICK, 1'b0, 8'd150, 8'd128, 1'b0, 2'b00);
    send_request(OP_TICK, 1'b0, 8'd150, 8'd128, 1'b1, 2'b00);
    send_request(OP_TICK, 1'b0, 8'd150, 8'd14, 1'b1, 2'b00);
    send_request(OP_TICK, 1'b0, 8'd100, 8'd128, 1'b1, 2'b00);
  endtask

  task automatic test_countdown_announcements();
    idle_bank();
    apply_setting(MODE_ABS, MODE_SWITCH, 35, 65, 1, 3, 1, 1);
    send_request(OP_RESET, 1'b0, 8'd0, 8'd0, 1'b1, 2'b00);
    send_request(OP_RESET, 1'b1, 8'd0, 8'd0, 1'b1, 2'b00);
    run_ticks(160);
  endtask

  task automatic test_value_limits();
    idle_bank();
    apply_setting(MODE_ABS, MODE_ABS, 32750, 32767, 0, 0, 0, 0);
    send_request(OP_RESET, 1'b0, 8'd0, 8'd0, 1'b1, 2'b00);
    send_request(OP_RESET, 1'b1, 8'd0, 8'd0, 1'b1, 2'b00);
    idle_bank();
    apply_setting(MODE_ABS, MODE_ABS, 0, 0, 0, 0, 1, 1);
    run_ticks(25);
    idle_bank();
    apply_setting(MODE_ABS, MODE_THR, 32760, 0, 3, 0, 1, 0);
    send_request(OP_RESET, 1'b0, 8'd0, 8'd0, 1'b1, 2'b00);
    idle_bank();
    apply_setting(MODE_ABS, MODE_THR, 1000, 0, 3, 0, 1, 0);
    run_ticks(10);
  endtask

  task automatic test_receiver_hold_off();
    idle_bank();
    apply_setting(MODE_ABS, MODE_REL, 0, 40, 1, 2, 1, 0);
    hold_off = 1'b1;
    repeat (30) random_request();
  endtask

  task automatic test_random_phases();
    int phase;
    int len;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      idle_bank();
      steady_flow = (phase == 4);
      apply_setting(pick_mode(), pick_mode(), pick_start(), pick_start(),
                    $urandom_range(3), $urandom_range(3), $urandom_range(1), $urandom_range(1));
      if ($urandom_range(99) < 70) begin
        send_request(OP_RESET, 1'b0, pick_tick(), pick_throttle(), 1'b1, $urandom_range(3));
        send_request(OP_RESET, 1'b1, pick_tick(), pick_throttle(), 1'b1, $urandom_range(3));
      end
      len = $urandom_range(20, 80);
      repeat (len) random_request();
    end
    steady_flow = 1'b0;
  endtask

  task automatic report_field(string name, logic signed [16:0] want, logic signed [16:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    timer_report_t got;
    timer_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.which = m_tdata[0];
      got.value = m_tdata[16:1];
      got.state = m_tdata[18:17];
      got.ann = m_tdata[21:19];
      got.beep = m_tdata[23:22];
      got.last = m_tlast;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        report_field("which_timer", want.which, got.which);
        report_field("timer_value", $signed(want.value), $signed(got.value));
        report_field("run_state", want.state, got.state);
        report_field("announce", want.ann, got.ann);
        report_field("beep_kind", want.beep, got.beep);
        report_field("last", want.last, got.last);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else if (!steady_flow && $urandom_range(99) < 35) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      mode_reg[i] = MODE_OFF;
      start_reg[i] = 0;
      kind_reg[i] = '0;
      minute_reg[i] = 1'b0;
      run_st[i] = RS_OFF;
      secs[i] = 0;
      centi[i] = 0;
      thr_acc[i] = '0;
      thr_samples[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_countdown_announcements();
    test_value_limits();
    test_receiver_hold_off();
    test_random_phases();
    idle_bank();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/mmft_pkg.sv
hdl/multi_mode_flight_timer.sv
dv/multi_mode_flight_timer_tb.sv
